### rtl/mean_background_subtractor_assert.svh
`ifndef MEAN_BACKGROUND_SUBTRACTOR_ASSERT_SVH
`define MEAN_BACKGROUND_SUBTRACTOR_ASSERT_SVH

// Implication checked in the same cycle.
`define MBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mbs check failed");

// Implication checked in the next cycle.
`define MBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mbs check failed");

`endif

### rtl/mbs_pkg.sv
package mbs_pkg;

  localparam int unsigned PixelW        = 8;
  localparam int unsigned IndexW        = 16;
  localparam int unsigned FramesW       = 11;
  localparam int unsigned SumW          = 18;
  localparam int unsigned FrameBytesDef = 65536;
  localparam int unsigned MaxFramesDef  = 1024;
  localparam int unsigned QueueDepth    = 4;

  localparam logic [SumW-1:0]   SumMax   = '1;
  localparam logic [PixelW-1:0] PixelMax = '1;

  localparam logic MODE_LEARN = 1'b0;
  localparam logic MODE_APPLY = 1'b1;

  typedef enum logic [2:0] {
    OP_LEARN_SET,
    OP_LEARN_ADD,
    OP_LEARN_SKIP,
    OP_APPLY,
    OP_PASS
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [PixelW-1:0]  pixel;
    logic [IndexW-1:0]  index;
    logic [FramesW-1:0] divisor;
    logic               ready_res;
  } cmd_t;

endpackage

### rtl/mbs_front.sv
module mbs_front
  import mbs_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = FrameBytesDef,
  parameter int unsigned MAX_FRAMES  = MaxFramesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [FramesW-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               in_mode_i,
  input  logic [PixelW-1:0]  in_pixel_i,
  input  logic [IndexW-1:0]  in_index_i,
  input  logic               in_last_i,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i,
  output cmd_t               cmd_o
);

  logic [FramesW-1:0] sample_q;
  logic [FramesW-1:0] count_q, count_d;
  logic               ready_q, ready_d;
  logic [FramesW-1:0] target;
  logic [FramesW-1:0] base_count;
  logic [FramesW-1:0] inc_count;
  logic               in_range;
  logic               accept;

  assign in_ready_o  = cmd_ready_i;
  assign cmd_valid_o = in_valid_i;
  assign accept      = in_valid_i && cmd_ready_i;

  always_comb begin
    if (sample_q == '0) begin
      target = FramesW'(1);
    end else if (32'(sample_q) > MAX_FRAMES) begin
      target = FramesW'(MAX_FRAMES);
    end else begin
      target = sample_q;
    end
  end

  assign in_range   = 32'(in_index_i) < FRAME_BYTES;
  // learn after ready starts a fresh pass
  assign base_count = ready_q ? '0 : count_q;
  assign inc_count  = base_count + FramesW'(1);

  always_comb begin
    count_d         = count_q;
    ready_d         = ready_q;
    cmd_o.pixel     = in_pixel_i;
    cmd_o.index     = in_index_i;
    cmd_o.divisor   = count_q;
    if (in_mode_i == MODE_LEARN) begin
      count_d = in_last_i ? inc_count : base_count;
      ready_d = in_last_i && (inc_count >= target);
      if (!in_range) begin
        cmd_o.op = OP_LEARN_SKIP;
      end else if (base_count == '0) begin
        cmd_o.op = OP_LEARN_SET;
      end else begin
        cmd_o.op = OP_LEARN_ADD;
      end
    end else begin
      cmd_o.op = (ready_q && in_range && count_q != '0) ? OP_APPLY : OP_PASS;
    end
    cmd_o.ready_res = ready_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= FramesW'(1);
      count_q  <= '0;
      ready_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        sample_q <= cfg_wdata_i;
      end
      if (accept) begin
        count_q <= count_d;
        ready_q <= ready_d;
      end
    end
  end

endmodule

### rtl/mbs_queue.sv
module mbs_queue
  import mbs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  cmd_t in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t out_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = PtrW + 1;

  cmd_t            slot_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign in_ready_o  = cnt_q != CntW'(QueueDepth);
  assign out_valid_o = cnt_q != '0;
  assign out_o       = slot_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

### rtl/mbs_back.sv
module mbs_back
  import mbs_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = FrameBytesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  cmd_t              cmd_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [PixelW-1:0] out_pixel_o,
  output logic              out_applied_o,
  output logic              out_ready_res_o
);

  localparam int unsigned AddrW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int unsigned StepW = $clog2(PixelW);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_CHK,
    S_DIV,
    S_EMIT
  } state_e;

  state_e             state_q;
  cmd_t               cur_q;
  logic [SumW-1:0]    mem [FRAME_BYTES];
  logic [SumW-1:0]    rdata_q;
  logic [SumW-1:0]    rem_q;
  logic [SumW-1:0]    dsh_q;
  logic [PixelW-1:0]  quot_q;
  logic [StepW-1:0]   step_q;
  logic               out_valid_q;
  logic [PixelW-1:0]  out_pixel_q;
  logic               out_applied_q;
  logic               out_ready_res_q;

  logic               out_free;
  logic               pop;
  logic               mem_we, mem_re;
  logic [AddrW-1:0]   waddr, raddr;
  logic [SumW-1:0]    wdata;
  logic [SumW:0]      sum_ext;
  logic [SumW-1:0]    sum_sat;
  logic               bg_over;
  logic               div_ge;
  logic [PixelW-1:0]  diff;
  logic               emit;
  logic [PixelW-1:0]  emit_pixel;
  logic               emit_applied;
  logic               emit_ready;

  assign out_free    = !out_valid_q || out_ready_i;
  assign cmd_ready_o = (state_q == S_IDLE) && out_free;
  assign pop         = cmd_valid_i && cmd_ready_o;

  assign sum_ext = {1'b0, rdata_q} + (SumW+1)'(cur_q.pixel);
  assign sum_sat = sum_ext[SumW] ? SumMax : sum_ext[SumW-1:0];
  // quotient would not fit in a byte: background clips at full scale
  assign bg_over = {1'b0, rdata_q} >= {cur_q.divisor, {PixelW{1'b0}}};
  assign div_ge  = rem_q >= dsh_q;
  assign diff    = (cur_q.pixel > quot_q) ? cur_q.pixel - quot_q : '0;

  assign raddr  = AddrW'(cmd_i.index);
  assign mem_re = pop && (cmd_i.op == OP_LEARN_ADD || cmd_i.op == OP_APPLY);

  always_comb begin
    emit         = 1'b0;
    emit_pixel   = '0;
    emit_applied = 1'b0;
    emit_ready   = cur_q.ready_res;
    mem_we       = 1'b0;
    waddr        = AddrW'(cur_q.index);
    wdata        = sum_sat;
    unique case (state_q)
      S_IDLE: begin
        emit_ready = cmd_i.ready_res;
        waddr      = AddrW'(cmd_i.index);
        wdata      = SumW'(cmd_i.pixel);
        if (pop) begin
          unique case (cmd_i.op) inside
            OP_LEARN_SET: begin
              emit   = 1'b1;
              mem_we = 1'b1;
            end
            OP_LEARN_SKIP: begin
              emit = 1'b1;
            end
            OP_PASS: begin
              emit       = 1'b1;
              emit_pixel = cmd_i.pixel;
            end
            OP_LEARN_ADD, OP_APPLY: begin
              emit = 1'b0;
            end
            default: begin
              emit = 1'b0;
            end
          endcase
        end
      end
      S_ADD: begin
        emit   = out_free;
        mem_we = out_free;
      end
      S_EMIT: begin
        emit         = out_free;
        emit_pixel   = diff;
        emit_applied = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      cur_q           <= '0;
      rem_q           <= '0;
      dsh_q           <= '0;
      quot_q          <= '0;
      step_q          <= '0;
      out_valid_q     <= 1'b0;
      out_pixel_q     <= '0;
      out_applied_q   <= 1'b0;
      out_ready_res_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (pop) begin
            cur_q <= cmd_i;
            if (cmd_i.op == OP_LEARN_ADD) begin
              state_q <= S_ADD;
            end else if (cmd_i.op == OP_APPLY) begin
              state_q <= S_CHK;
            end
          end
        end
        S_ADD: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        S_CHK: begin
          if (bg_over) begin
            quot_q  <= PixelMax;
            state_q <= S_EMIT;
          end else begin
            rem_q   <= rdata_q;
            dsh_q   <= {cur_q.divisor, {(SumW-FramesW){1'b0}}};
            quot_q  <= '0;
            step_q  <= StepW'(PixelW - 1);
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          // restoring division, one quotient bit per cycle
          if (div_ge) begin
            rem_q <= rem_q - dsh_q;
          end
          quot_q <= {quot_q[PixelW-2:0], div_ge};
          dsh_q  <= dsh_q >> 1;
          step_q <= step_q - StepW'(1);
          if (step_q == '0) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase

      if (emit) begin
        out_valid_q     <= 1'b1;
        out_pixel_q     <= emit_pixel;
        out_applied_q   <= emit_applied;
        out_ready_res_q <= emit_ready;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_pixel_o     = out_pixel_q;
  assign out_applied_o   = out_applied_q;
  assign out_ready_res_o = out_ready_res_q;

endmodule

### rtl/mean_background_subtractor.sv
// Throughput: 1 item/cycle for single-access items while the output is not stalled;
// an accumulate holds the back end for a memory read then write, an apply for read,
// check, 8-step divider and emit; the back end takes no new item until it is done.
// Reset clears counters, ready flag and queue; the background memory is not cleared.
module mean_background_subtractor
  import mbs_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = FrameBytesDef,
  parameter int unsigned MAX_FRAMES  = MaxFramesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [FramesW-1:0] cfg_wdata_i,   // sample_frames
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [23:0]        s_axis_tdata,  // [7:0] pixel, [23:8] pixel_index
  input  logic [0:0]         s_axis_tuser,  // [0] mode
  input  logic               s_axis_tlast,  // frame_end
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata,  // [7:0] out_pixel
  output logic [1:0]         m_axis_tuser   // [0] applied, [1] ready_res
);

  logic cmd_valid, cmd_ready;
  cmd_t cmd;
  logic q_valid, q_ready;
  cmd_t q_cmd;

  mbs_front #(
    .FRAME_BYTES(FRAME_BYTES),
    .MAX_FRAMES (MAX_FRAMES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_mode_i  (s_axis_tuser[0]),
    .in_pixel_i (s_axis_tdata[7:0]),
    .in_index_i (s_axis_tdata[23:8]),
    .in_last_i  (s_axis_tlast),
    .cmd_valid_o(cmd_valid),
    .cmd_ready_i(cmd_ready),
    .cmd_o      (cmd)
  );

  mbs_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_valid),
    .in_ready_o (cmd_ready),
    .in_i       (cmd),
    .out_valid_o(q_valid),
    .out_ready_i(q_ready),
    .out_o      (q_cmd)
  );

  mbs_back #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (q_valid),
    .cmd_ready_o    (q_ready),
    .cmd_i          (q_cmd),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_pixel_o    (m_axis_tdata),
    .out_applied_o  (m_axis_tuser[0]),
    .out_ready_res_o(m_axis_tuser[1])
  );

endmodule

### rtl/mbs_checker.sv
`include "mean_background_subtractor_assert.svh"

module mbs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser
);

  `MBS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  `MBS_ASSERT_IMP(a_applied_needs_ready, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0], m_axis_tuser[1])
  `MBS_ASSERT_IMP(a_quiet_after_reset, clk_i, rst_ni, $rose(rst_ni), !m_axis_tvalid)

endmodule

bind mean_background_subtractor mbs_checker u_mbs_checker (.*);
